>>> hw/rtl/kms_pkg.sv
package kms_pkg;

  localparam int BUFFER_DEPTH = 4;
  localparam int COUNT_W      = 3;
  localparam int SLOT_W       = 2;
  localparam int CODE_W       = 7;
  localparam int QUIET_W      = 8;
  localparam int MASK_W       = 16;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_EDGE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_DISABLED = 1'b1;

  localparam logic [QUIET_W-1:0] DEBOUNCE_RESET = 8'd16;
  localparam logic [MASK_W-1:0]  DISABLED_RESET = 16'h5000;
  localparam logic [QUIET_W-1:0] QUIET_MAX      = 8'd255;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] column_levels;
    logic [1:0] edge_column;
  } item_t;

  typedef struct packed {
    logic [3:0]         row_drive;
    logic               key_valid;
    logic [CODE_W-1:0]  key_code;
    logic [SLOT_W-1:0]  key_slot;
    logic [COUNT_W-1:0] key_count;
    logic               overflow;
  } result_t;

  function automatic logic [CODE_W-1:0] key_ascii(input logic [3:0] pos);
    logic [CODE_W-1:0] code;
    case (pos)
      4'd0:    code = 7'h31;
      4'd1:    code = 7'h32;
      4'd2:    code = 7'h33;
      4'd3:    code = 7'h41;
      4'd4:    code = 7'h34;
      4'd5:    code = 7'h35;
      4'd6:    code = 7'h36;
      4'd7:    code = 7'h42;
      4'd8:    code = 7'h37;
      4'd9:    code = 7'h38;
      4'd10:   code = 7'h39;
      4'd11:   code = 7'h43;
      4'd12:   code = 7'h2A;
      4'd13:   code = 7'h30;
      4'd14:   code = 7'h23;
      default: code = 7'h44;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/kms_in_stage.sv
module kms_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kms_pkg::item_t      in_item,
  input  logic                take,
  output logic                item_valid,
  output kms_pkg::item_t      item
);

  logic           valid_r, valid_nxt;
  kms_pkg::item_t item_r;
  logic           accept;

  assign in_stall   = valid_r & ~take;
  assign accept     = in_valid & ~in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

>>> hw/rtl/kms_engine.sv
module kms_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  kms_pkg::item_t                item,
  input  logic [kms_pkg::QUIET_W-1:0]   debounce_ticks,
  input  logic [kms_pkg::MASK_W-1:0]    disabled_keys,
  output kms_pkg::result_t              result
);

  logic [1:0]                        scan_phase_r, scan_phase_nxt;
  logic [1:0]                        current_row_r, current_row_nxt;
  logic [3:0]                        drive_pattern_r, drive_pattern_nxt;
  logic [kms_pkg::QUIET_W-1:0]       quiet_ticks_r, quiet_ticks_nxt;
  logic [kms_pkg::COUNT_W-1:0]       stored_count_r, stored_count_nxt;
  logic [3:0]                        pos;
  logic                              ok;
  logic                              full;

  assign pos  = {current_row_r, item.edge_column};
  assign ok   = (quiet_ticks_r >= debounce_ticks) && item.column_levels[item.edge_column]
                && !disabled_keys[pos];
  assign full = stored_count_r >= kms_pkg::COUNT_W'(kms_pkg::BUFFER_DEPTH);

  always_comb begin
    scan_phase_nxt    = scan_phase_r;
    current_row_nxt   = current_row_r;
    drive_pattern_nxt = drive_pattern_r;
    quiet_ticks_nxt   = quiet_ticks_r;
    stored_count_nxt  = stored_count_r;
    result            = '0;
    case (item.func)
      kms_pkg::FUNC_TICK: begin
        if (quiet_ticks_r != kms_pkg::QUIET_MAX) begin
          quiet_ticks_nxt = quiet_ticks_r + 1'b1;
        end
        if (item.column_levels == 4'd0) begin
          current_row_nxt   = scan_phase_r;
          drive_pattern_nxt = 4'd1 << scan_phase_r;
          scan_phase_nxt    = scan_phase_r + 1'b1;
        end
      end
      kms_pkg::FUNC_EDGE: begin
        if (ok) begin
          if (full) begin
            result.overflow = 1'b1;
          end else begin
            result.key_code  = kms_pkg::key_ascii(pos);
            result.key_slot  = stored_count_r[kms_pkg::SLOT_W-1:0];
            result.key_valid = 1'b1;
            stored_count_nxt = stored_count_r + 1'b1;
            quiet_ticks_nxt  = '0;
          end
        end
      end
      kms_pkg::FUNC_CLEAR: begin
        stored_count_nxt = '0;
      end
      default: begin
      end
    endcase
    result.row_drive = drive_pattern_nxt;
    result.key_count = stored_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_phase_r    <= '0;
      current_row_r   <= '0;
      drive_pattern_r <= '0;
      quiet_ticks_r   <= '0;
      stored_count_r  <= '0;
    end else if (fire) begin
      scan_phase_r    <= scan_phase_nxt;
      current_row_r   <= current_row_nxt;
      drive_pattern_r <= drive_pattern_nxt;
      quiet_ticks_r   <= quiet_ticks_nxt;
      stored_count_r  <= stored_count_nxt;
    end
  end

endmodule

>>> hw/rtl/kms_out_stage.sv
module kms_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  kms_pkg::result_t             result,
  output logic                         ready_for_load,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   out_row_drive,
  output logic                         out_key_valid,
  output logic [kms_pkg::CODE_W-1:0]   out_key_code,
  output logic [kms_pkg::SLOT_W-1:0]   out_key_slot,
  output logic [kms_pkg::COUNT_W-1:0]  out_key_count,
  output logic                         out_overflow
);

  logic             valid_r, valid_nxt;
  kms_pkg::result_t result_r;

  assign ready_for_load = ~valid_r | ~out_stall;
  assign out_valid      = valid_r;
  assign out_row_drive  = result_r.row_drive;
  assign out_key_valid  = result_r.key_valid;
  assign out_key_code   = result_r.key_code;
  assign out_key_slot   = result_r.key_slot;
  assign out_key_count  = result_r.key_count;
  assign out_overflow   = result_r.overflow;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

>>> hw/rtl/keypad_matrix_scanner.sv
// 4x4 keypad scanner with debounce and a four-entry key buffer. Each input
// transaction is an event (scan tick, column rising edge, buffer clear, or an
// unused function code, which changes no state) and yields exactly one result
// transaction. The block takes one event per clock cycle while the result side
// is not stalled; an accepted event is held in the input register and moves to
// the result register when that register is free, with the scanner state
// updated as the event moves from the first to the second. A stalled result
// holds the input register, which stalls the input. Configuration writes are
// always ready and must only be issued while no event is in flight.
module keypad_matrix_scanner (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_func,
  input  logic [3:0]                   in_column_levels,
  input  logic [1:0]                   in_edge_column,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   out_row_drive,
  output logic                         out_key_valid,
  output logic [kms_pkg::CODE_W-1:0]   out_key_code,
  output logic [kms_pkg::SLOT_W-1:0]   out_key_slot,
  output logic [kms_pkg::COUNT_W-1:0]  out_key_count,
  output logic                         out_overflow,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [kms_pkg::MASK_W-1:0]   cfg_wdata
);

  logic [kms_pkg::QUIET_W-1:0] debounce_ticks_r;
  logic [kms_pkg::MASK_W-1:0]  disabled_keys_r;
  kms_pkg::item_t              in_item;
  kms_pkg::item_t              item;
  kms_pkg::result_t            result;
  logic                        item_valid;
  logic                        out_free;
  logic                        fire;

  assign cfg_ready = 1'b1;
  assign in_item   = '{func: in_func, column_levels: in_column_levels,
                       edge_column: in_edge_column};
  assign fire      = item_valid & out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= kms_pkg::DEBOUNCE_RESET;
      disabled_keys_r  <= kms_pkg::DISABLED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kms_pkg::CFG_DEBOUNCE: debounce_ticks_r <= cfg_wdata[kms_pkg::QUIET_W-1:0];
        kms_pkg::CFG_DISABLED: disabled_keys_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  kms_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (out_free),
    .item_valid (item_valid),
    .item       (item)
  );

  kms_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .item           (item),
    .debounce_ticks (debounce_ticks_r),
    .disabled_keys  (disabled_keys_r),
    .result         (result)
  );

  kms_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (fire),
    .result         (result),
    .ready_for_load (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_drive  (out_row_drive),
    .out_key_valid  (out_key_valid),
    .out_key_code   (out_key_code),
    .out_key_slot   (out_key_slot),
    .out_key_count  (out_key_count),
    .out_overflow   (out_overflow)
  );

endmodule

>>> dv/keypad_event_checker.sv
`timescale 1ns / 1ps
module keypad_event_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [3:0]                  in_column_levels,
  input  logic [1:0]                  in_edge_column,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [3:0]                  out_row_drive,
  input  logic                        out_key_valid,
  input  logic [kms_pkg::CODE_W-1:0]  out_key_code,
  input  logic [kms_pkg::SLOT_W-1:0]  out_key_slot,
  input  logic [kms_pkg::COUNT_W-1:0] out_key_count,
  input  logic                        out_overflow,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [kms_pkg::MASK_W-1:0]  cfg_wdata,
  output int                          mismatches,
  output int                          outstanding
);

  localparam int REPORT_LIMIT = 10;

  logic [1:0]                  next_row;
  logic [1:0]                  active_row;
  logic [3:0]                  row_pattern;
  logic [kms_pkg::QUIET_W-1:0] quiet;
  logic [kms_pkg::COUNT_W-1:0] held;
  logic [kms_pkg::QUIET_W-1:0] debounce;
  logic [kms_pkg::MASK_W-1:0]  disabled;
  kms_pkg::result_t            predicted_reports[$];
  kms_pkg::result_t            observed;
  int                          fail_count;
  int                          report_index;

  assign observed = {out_row_drive, out_key_valid, out_key_code, out_key_slot,
                     out_key_count, out_overflow};

  function automatic logic [kms_pkg::CODE_W-1:0] key_char(input logic [1:0] row,
                                                          input logic [1:0] col);
    byte unsigned c;
    if (col == 2'd3) begin
      c = "A" + row;
    end else if (row != 2'd3) begin
      c = 8'("1" + 3 * row + col);
    end else if (col == 2'd0) begin
      c = "*";
    end else if (col == 2'd1) begin
      c = "0";
    end else begin
      c = "#";
    end
    return c[kms_pkg::CODE_W-1:0];
  endfunction

  task scan_event(input kms_pkg::item_t ev);
    kms_pkg::result_t rep;
    logic [3:0]       pos;
    rep = '0;
    pos = {active_row, ev.edge_column};
    case (ev.func)
      kms_pkg::FUNC_TICK: begin
        if (quiet != kms_pkg::QUIET_MAX) quiet = quiet + 1'b1;
        if (ev.column_levels == 4'd0) begin
          active_row  = next_row;
          row_pattern = 4'b0001 << next_row;
          next_row    = next_row + 1'b1;
        end
      end
      kms_pkg::FUNC_EDGE: begin
        if (quiet >= debounce && ev.column_levels[ev.edge_column] && !disabled[pos]) begin
          if (held >= kms_pkg::BUFFER_DEPTH) begin
            rep.overflow = 1'b1;
          end else begin
            rep.key_valid = 1'b1;
            rep.key_code  = key_char(active_row, ev.edge_column);
            rep.key_slot  = held[kms_pkg::SLOT_W-1:0];
            held          = held + 1'b1;
            quiet         = '0;
          end
        end
      end
      kms_pkg::FUNC_CLEAR: begin
        held = '0;
      end
      default: begin
      end
    endcase
    rep.row_drive = row_pattern;
    rep.key_count = held;
    predicted_reports.push_back(rep);
  endtask

  task check_report();
    kms_pkg::result_t want;
    report_index++;
    if (predicted_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display({"report %0d: unexpected transaction row %h valid %b code %h",
                  " slot %0d count %0d ovf %b"},
                 report_index, observed.row_drive, observed.key_valid, observed.key_code,
                 observed.key_slot, observed.key_count, observed.overflow);
    end else begin
      want = predicted_reports.pop_front();
      if (observed.row_drive !== want.row_drive || observed.key_valid !== want.key_valid ||
          observed.key_code !== want.key_code || observed.key_slot !== want.key_slot ||
          observed.key_count !== want.key_count || observed.overflow !== want.overflow) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display({"report %0d: expected row %h valid %b code %h slot %0d count %0d ovf %b,",
                    " got row %h valid %b code %h slot %0d count %0d ovf %b"},
                   report_index, want.row_drive, want.key_valid, want.key_code,
                   want.key_slot, want.key_count, want.overflow,
                   observed.row_drive, observed.key_valid, observed.key_code,
                   observed.key_slot, observed.key_count, observed.overflow);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      next_row    = '0;
      active_row  = '0;
      row_pattern = '0;
      quiet       = '0;
      held        = '0;
      debounce    = kms_pkg::DEBOUNCE_RESET;
      disabled    = kms_pkg::DISABLED_RESET;
      predicted_reports.delete();
    end else begin
      if (out_valid && !out_stall) check_report();
      if (in_valid && !in_stall) scan_event({in_func, in_column_levels, in_edge_column});
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kms_pkg::CFG_DEBOUNCE) debounce = cfg_wdata[kms_pkg::QUIET_W-1:0];
        else disabled = cfg_wdata;
      end
    end
    outstanding <= predicted_reports.size();
    mismatches  <= fail_count;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         PHASE_EVENTS = 200;

  logic                        clk;
  logic                        rst_n            = 1'b0;
  logic                        in_valid         = 1'b0;
  logic                        in_stall;
  logic [1:0]                  in_func          = '0;
  logic [3:0]                  in_column_levels = '0;
  logic [1:0]                  in_edge_column   = '0;
  logic                        out_valid;
  logic                        out_stall        = 1'b0;
  logic [3:0]                  out_row_drive;
  logic                        out_key_valid;
  logic [kms_pkg::CODE_W-1:0]  out_key_code;
  logic [kms_pkg::SLOT_W-1:0]  out_key_slot;
  logic [kms_pkg::COUNT_W-1:0] out_key_count;
  logic                        out_overflow;
  logic                        cfg_valid        = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_index        = 1'b0;
  logic [kms_pkg::MASK_W-1:0]  cfg_wdata        = '0;

  int                          mismatches;
  int                          outstanding;
  int                          send_gap_pct;
  int                          recv_stall_pct   = 51;
  int                          idle_cycles      = 0;
  int                          sent             = 0;
  logic [kms_pkg::QUIET_W-1:0] debounce_now;

  keypad_matrix_scanner u_top (.*);
  keypad_event_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("keypad_matrix_scanner: mismatch");
        $finish;
      end
    end
  end

  task send_event(input logic [1:0] func, input logic [3:0] cols, input logic [1:0] ecol);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= func;
    in_column_levels <= cols;
    in_edge_column   <= ecol;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // hold off until every predicted transaction has come back
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(input logic idx, input logic [kms_pkg::MASK_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == kms_pkg::CFG_DEBOUNCE) debounce_now = data[kms_pkg::QUIET_W-1:0];
  endtask

  // quiet ticks, then an edge on a column that is usually still high, sometimes followed by a clear
  task send_press();
    int         n;
    logic [1:0] col;
    logic [3:0] cols;
    n = $urandom_range(0, int'(debounce_now) + 2);
    repeat (n)
      send_event(kms_pkg::FUNC_TICK, ($urandom_range(7) == 0) ? 4'($urandom) : 4'd0,
                 2'($urandom));
    col  = 2'($urandom);
    cols = 4'($urandom);
    if ($urandom_range(9) != 0) cols[col] = 1'b1;
    send_event(kms_pkg::FUNC_EDGE, cols, col);
    if ($urandom_range(4) == 0) send_event(kms_pkg::FUNC_CLEAR, 4'($urandom), 2'($urandom));
  endtask

  initial begin
    int phase_end;
    int r;
    send_gap_pct = 22;
    debounce_now = kms_pkg::DEBOUNCE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_event(FUNC_UNUSED, 4'hF, 2'd3);
    send_event(kms_pkg::FUNC_EDGE, 4'b0001, 2'd0);
    send_event(kms_pkg::FUNC_CLEAR, 4'h0, 2'd0);
    write_reg(kms_pkg::CFG_DEBOUNCE, 16'h0000);
    write_reg(kms_pkg::CFG_DISABLED, 16'h0000);
    send_event(kms_pkg::FUNC_EDGE, 4'b0001, 2'd0);
    send_event(kms_pkg::FUNC_EDGE, 4'b1101, 2'd1);
    send_event(kms_pkg::FUNC_TICK, 4'hF, 2'd3);
    send_event(kms_pkg::FUNC_TICK, 4'h0, 2'd0);
    send_event(kms_pkg::FUNC_EDGE, 4'b1000, 2'd3);
    send_event(kms_pkg::FUNC_TICK, 4'h0, 2'd1);
    send_event(kms_pkg::FUNC_EDGE, 4'b0100, 2'd2);
    send_event(kms_pkg::FUNC_TICK, 4'h0, 2'd2);
    send_event(kms_pkg::FUNC_TICK, 4'h0, 2'd3);
    send_event(kms_pkg::FUNC_EDGE, 4'hF, 2'd0);
    send_event(kms_pkg::FUNC_EDGE, 4'hF, 2'd2);
    send_event(FUNC_UNUSED, 4'h0, 2'd0);
    send_event(kms_pkg::FUNC_CLEAR, 4'hF, 2'd3);
    send_event(kms_pkg::FUNC_EDGE, 4'b0010, 2'd1);

    // saturate the quiet counter against the largest threshold
    write_reg(kms_pkg::CFG_DEBOUNCE, {8'($urandom), 8'hFF});
    write_reg(kms_pkg::CFG_DISABLED, 16'hFFFF);
    repeat (260) send_event(kms_pkg::FUNC_TICK, 4'($urandom), 2'($urandom));
    send_event(kms_pkg::FUNC_EDGE, 4'hF, 2'($urandom));
    write_reg(kms_pkg::CFG_DISABLED, 16'h0000);
    send_event(kms_pkg::FUNC_EDGE, 4'hF, 2'($urandom));

    for (int p = 0; p < 5; p++) begin
      if (p == 2) begin
        send_gap_pct = 51;
        recv_stall_pct <= 22;
      end
      if (p == 4) begin
        send_gap_pct = 0;
        recv_stall_pct <= 0;
      end
      write_reg(kms_pkg::CFG_DEBOUNCE, {8'($urandom), 8'($urandom_range(0, 2 * p + 1))});
      write_reg(kms_pkg::CFG_DISABLED,
                (p == 3) ? kms_pkg::DISABLED_RESET : 16'($urandom & $urandom));
      phase_end = sent + PHASE_EVENTS;
      while (sent < phase_end) begin
        r = $urandom_range(99);
        if (r < 70) send_press();
        else if (r < 98) send_event(2'($urandom), 4'($urandom), 2'($urandom));
        else drain();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("keypad_matrix_scanner: match");
    end else begin
      $display("keypad_matrix_scanner: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/kms_pkg.sv
hw/rtl/kms_in_stage.sv
hw/rtl/kms_engine.sv
hw/rtl/kms_out_stage.sv
hw/rtl/keypad_matrix_scanner.sv
dv/keypad_event_checker.sv
dv/tb.sv
